// ===== hw/rtl/text_console_char_writer_defines.svh =====
// assertion macros shared by the console writer modules
`ifndef TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define TCW_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCW_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tcw_pkg.sv =====
package tcw_pkg;

  localparam int COLUMNS_DEF   = 80;
  localparam int ROWS_DEF      = 25;
  localparam int TAB_WIDTH_DEF = 8;

  localparam int OP_W     = 2;
  localparam int CHAR_W   = 8;
  localparam int IDX_W    = 11;
  localparam int POS_W    = 11;
  localparam int CELL_W   = 16;
  localparam int COLOR_W  = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOR  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRONT_COLOR = 1'd1;

  localparam logic [COLOR_W-1:0] BACK_COLOR_RST  = 4'd0;
  localparam logic [COLOR_W-1:0] FRONT_COLOR_RST = 4'd7;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_LAST = 8'h7F;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_PUT,
    ST_READ,
    ST_COPY,
    ST_FILL,
    ST_RESP
  } state_t;

  typedef enum logic [2:0] {
    MM_NONE,
    MM_PUT,
    MM_READ,
    MM_COPY,
    MM_FILL
  } mem_mode_t;

  typedef struct packed {
    logic      load;
    logic      put;
    logic      home;
    logic      cnt_zero;
    logic      cnt_row;
    logic      cnt_inc;
    mem_mode_t mem_mode;
    logic      fill_zero;
    logic      respond;
  } ctl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic scroll_req;
    logic copy_end;
    logic fill_end;
  } dp_stat_t;

endpackage

// ===== hw/rtl/tcw_ram.sv =====
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/tcw_ctrl.sv =====
`include "text_console_char_writer_defines.svh"

module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (stat.fill_end) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        case (stat.op)
          OP_PUT:   state_nxt = ST_PUT;
          OP_READ:  state_nxt = ST_READ;
          OP_CLEAR: state_nxt = ST_FILL;
          default:  state_nxt = ST_RESP;
        endcase
      end
      ST_PUT: begin
        state_nxt = stat.scroll_req ? ST_COPY : ST_RESP;
      end
      ST_READ: begin
        state_nxt = ST_RESP;
      end
      ST_COPY: begin
        if (stat.copy_end) state_nxt = ST_FILL;
      end
      ST_FILL: begin
        if (stat.fill_end) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_INIT: begin
        cmd.mem_mode  = MM_FILL;
        cmd.fill_zero = 1'b1;
        cmd.cnt_inc   = 1'b1;
      end
      ST_IDLE: begin
        busy         = 1'b0;
        cmd.load     = start;
        cmd.cnt_zero = 1'b1;
      end
      ST_DECODE: begin
        cmd.home = (stat.op == OP_CLEAR);
      end
      ST_PUT: begin
        cmd.mem_mode = MM_PUT;
        cmd.put      = 1'b1;
      end
      ST_READ: begin
        cmd.mem_mode = MM_READ;
      end
      ST_COPY: begin
        cmd.mem_mode = MM_COPY;
        // hand over to the last-row blanking once the final row is copied
        cmd.cnt_row  = stat.copy_end;
        cmd.cnt_inc  = !stat.copy_end;
      end
      ST_FILL: begin
        cmd.mem_mode = MM_FILL;
        cmd.cnt_inc  = 1'b1;
      end
      ST_RESP: begin
        cmd.respond = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  `TCW_ASSERT_NXT(a_copy_to_fill, (state_r == ST_COPY) && stat.copy_end,
                  state_r == ST_FILL, "scroll copy did not hand over to row blanking")
  `TCW_ASSERT_NXT(a_put_no_scroll, (state_r == ST_PUT) && !stat.scroll_req,
                  state_r == ST_RESP, "put without scroll did not respond")
  `TCW_ASSERT_NXT(a_resp_idle, state_r == ST_RESP, !busy, "busy after response")

endmodule

// ===== hw/rtl/tcw_dp.sv =====
`include "text_console_char_writer_defines.svh"

module tcw_dp
  import tcw_pkg::*;
#(
  parameter int COLUMNS   = COLUMNS_DEF,
  parameter int ROWS      = ROWS_DEF,
  parameter int TAB_WIDTH = TAB_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_data,
  input  logic [OP_W-1:0]      in_op,
  input  logic [CHAR_W-1:0]    in_char_code,
  input  logic [IDX_W-1:0]     in_cell_index,
  input  ctl_cmd_t             cmd,
  output dp_stat_t             stat,
  output logic                 out_valid,
  output logic [POS_W-1:0]     out_cursor_pos,
  output logic [CELL_W-1:0]    out_cell_data
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CNT_W = $clog2(CELLS + 1);
  localparam int C_W   = $clog2(COLUMNS);
  localparam int R_W   = $clog2(ROWS);
  localparam int RB_W  = R_W + 1;
  localparam int P_W   = $clog2(TAB_WIDTH);
  localparam int CA_W  = $clog2(COLUMNS + TAB_WIDTH);

  // latched item
  logic [OP_W-1:0]   op_r;
  logic [CHAR_W-1:0] char_r;
  logic [IDX_W-1:0]  idx_r;

  logic [C_W-1:0]     col_r, col_nxt;
  logic [R_W-1:0]     row_r, row_nxt;
  logic [P_W-1:0]     phase_r, phase_nxt;
  logic [COLOR_W-1:0] back_r, back_nxt;
  logic [COLOR_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]   out_pos_r, out_pos_nxt;
  logic [CELL_W-1:0]  out_data_r, out_data_nxt;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata, mem_rdata;

  logic [CELL_W-1:0] blank;
  logic [AW-1:0]     lin;
  logic              is_bs, is_tab, is_lf, is_cr, is_print;
  logic [CA_W-1:0]   col_a;
  logic [P_W-1:0]    phase_a;
  logic              wrap;
  logic [RB_W-1:0]   row_b;
  logic              scroll;
  logic              put_we;
  logic [AW-1:0]     put_addr;
  logic [CELL_W-1:0] put_data;
  logic              idx_ok;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign blank = {back_r, front_r, CH_SPACE};
  assign lin   = AW'(row_r) * AW'(COLUMNS) + AW'(col_r);

  // character decode and cursor motion for one put
  always_comb begin
    is_bs    = (char_r == CH_BS) && (col_r != '0);
    is_tab   = (char_r == CH_TAB);
    is_lf    = (char_r == CH_LF);
    is_cr    = (char_r == CH_CR);
    is_print = !char_r[CHAR_W-1] && (char_r >= CH_SPACE);

    col_a   = CA_W'(col_r);
    phase_a = phase_r;
    if (is_bs) begin
      col_a   = CA_W'(col_r) - CA_W'(1);
      phase_a = (phase_r == '0) ? P_W'(TAB_WIDTH - 1) : phase_r - P_W'(1);
    end else if (is_tab) begin
      col_a   = CA_W'(col_r) + CA_W'(TAB_WIDTH) - CA_W'(phase_r);
      phase_a = '0;
    end else if (is_lf || is_cr) begin
      col_a   = '0;
      phase_a = '0;
    end else if (is_print) begin
      col_a   = CA_W'(col_r) + CA_W'(1);
      phase_a = (phase_r == P_W'(TAB_WIDTH - 1)) ? '0 : phase_r + P_W'(1);
    end

    wrap   = (col_a >= CA_W'(COLUMNS));
    row_b  = {1'b0, row_r} + RB_W'(is_lf || wrap);
    scroll = (row_b >= RB_W'(ROWS));

    put_we   = is_bs || is_print;
    put_addr = is_bs ? lin - AW'(1) : lin;
    put_data = is_bs ? blank : {back_r, front_r, char_r};
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    case (cmd.mem_mode)
      MM_PUT: begin
        mem_we    = put_we;
        mem_waddr = put_addr;
        mem_wdata = put_data;
      end
      MM_READ: begin
        mem_raddr = AW'(idx_r);
      end
      MM_COPY: begin
        // read one row ahead, write the word read last cycle one slot back
        if (cnt_r < CNT_W'(CELLS - COLUMNS)) begin
          mem_raddr = AW'(cnt_r + CNT_W'(COLUMNS));
        end
        mem_we    = (cnt_r != '0);
        mem_waddr = AW'(cnt_r - CNT_W'(1));
        mem_wdata = mem_rdata;
      end
      MM_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(cnt_r);
        mem_wdata = cmd.fill_zero ? '0 : blank;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign idx_ok = (int'(idx_r) < CELLS);

  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    phase_nxt     = phase_r;
    back_nxt      = back_r;
    front_nxt     = front_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = cmd.respond;
    out_pos_nxt   = out_pos_r;
    out_data_nxt  = out_data_r;

    if (cmd.put) begin
      col_nxt   = wrap ? '0 : col_a[C_W-1:0];
      phase_nxt = wrap ? '0 : phase_a;
      row_nxt   = scroll ? R_W'(ROWS - 1) : row_b[R_W-1:0];
    end else if (cmd.home) begin
      col_nxt   = '0;
      row_nxt   = '0;
      phase_nxt = '0;
    end

    if (cmd.cnt_zero) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_row) begin
      cnt_nxt = CNT_W'(CELLS - COLUMNS);
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end

    if (cfg_we) begin
      unique case (cfg_index)
        REG_BACK_COLOR:  back_nxt  = cfg_data;
        REG_FRONT_COLOR: front_nxt = cfg_data;
      endcase
    end

    if (cmd.respond) begin
      out_pos_nxt  = POS_W'(lin);
      out_data_nxt = (op_r == OP_READ && idx_ok) ? mem_rdata : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      phase_r     <= '0;
      back_r      <= BACK_COLOR_RST;
      front_r     <= FRONT_COLOR_RST;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      phase_r     <= phase_nxt;
      back_r      <= back_nxt;
      front_r     <= front_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      char_r <= in_char_code;
      idx_r  <= in_cell_index;
    end
    out_pos_r  <= out_pos_nxt;
    out_data_r <= out_data_nxt;
  end

  assign stat.op         = op_t'(op_r);
  assign stat.scroll_req = scroll;
  assign stat.copy_end   = (cnt_r == CNT_W'(CELLS - COLUMNS));
  assign stat.fill_end   = (cnt_r == CNT_W'(CELLS - 1));

  assign out_valid      = out_valid_r;
  assign out_cursor_pos = out_pos_r;
  assign out_cell_data  = out_data_r;

  `TCW_ASSERT_NXT(a_single_word, out_valid_r, !out_valid_r, "back-to-back result words")
  `TCW_ASSERT_NXT(a_row_range, cmd.put, int'(row_r) < ROWS, "cursor row out of range")
  `TCW_ASSERT_NXT(a_col_range, cmd.put, int'(col_r) < COLUMNS, "cursor column out of range")

endmodule

// ===== hw/rtl/text_console_char_writer.sv =====
// channel   | ports                                         | handshake
// ----------+-----------------------------------------------+------------------------------
// input     | in_op, in_char_code, in_cell_index            | taken when start && !busy
// result    | out_cursor_pos, out_cell_data                 | out_valid high for one cycle
// config    | cfg_index, cfg_data                           | written when cfg_we is high
//
// a plain put and a read step decode, put/read, response; unused ops skip to response.
// clear walks the screen store one word a cycle, writing a blank to every cell.
// a put that scrolls copies each row below the top one row up through the store's
// one read port and one write port, then blanks the last row.
// after reset a clearing pass zeroes the store, with busy high.
// the receiver cannot stall; each result word is shown once, one cycle, as busy falls.
module text_console_char_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS   = COLUMNS_DEF,
  parameter int ROWS      = ROWS_DEF,
  parameter int TAB_WIDTH = TAB_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [OP_W-1:0]      in_op,
  input  logic [CHAR_W-1:0]    in_char_code,
  input  logic [IDX_W-1:0]     in_cell_index,
  output logic                 out_valid,
  output logic [POS_W-1:0]     out_cursor_pos,
  output logic [CELL_W-1:0]    out_cell_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_data
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  tcw_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  tcw_dp #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_op          (in_op),
    .in_char_code   (in_char_code),
    .in_cell_index  (in_cell_index),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_cursor_pos (out_cursor_pos),
    .out_cell_data  (out_cell_data)
  );

endmodule
